// File: sv/prcacc_pkg.sv
package prcacc_pkg;

  localparam int unsigned MaxIntervalDef = 32768;
  localparam int unsigned MaxInsertDef   = 1000;

  localparam logic [11:0] MaskF1R2   = 12'd97;
  localparam logic [11:0] MaskF2R1   = 12'd161;
  localparam int unsigned FirstInPairBit = 6;
  localparam logic [7:0]  MinQualityReset = 8'd20;

  typedef enum logic [1:0] {
    MODE_RECORD   = 2'd0,
    MODE_POSITION = 2'd1,
    MODE_BIN      = 2'd2,
    MODE_CLEAR    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_FIRST   = 2'd0,
    CFG_LAST    = 2'd1,
    CFG_QUALITY = 2'd2,
    CFG_NONE    = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP1,
    ST_SETUP2,
    ST_SETUP3,
    ST_ROW_RD,
    ST_ROW_WR,
    ST_HIST_RD,
    ST_HIST_BIN,
    ST_HIST_TOTAL,
    ST_HIST_TALLY,
    ST_FETCH,
    ST_FETCH_DATA,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [11:0]        read_flags;
    logic [7:0]         map_quality;
    logic               mate_same_contig;
    logic [30:0]        left_position;
    logic signed [31:0] template_length;
    logic [14:0]        readback_index;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] forward_depth;
    logic [15:0] reverse_cover;
    logic [16:0] total_depth;
    logic [15:0] forward_starts;
    logic [15:0] forward_ends;
    logic [15:0] reverse_starts;
    logic [15:0] reverse_ends;
    logic [31:0] bin_count;
    logic [31:0] sum_of_inserts;
    logic [31:0] number_of_inserts;
  } out_t;

  typedef struct packed {
    logic [15:0] fwd_depth;
    logic [15:0] rev_depth;
    logic [15:0] fwd_start;
    logic [15:0] fwd_end;
    logic [15:0] rev_start;
    logic [15:0] rev_end;
  } row_t;

  typedef struct packed {
    logic rev;
    logic at_start;
    logic at_end;
  } bump_ctrl_t;

endpackage

// File: sv/prcacc_mem.sv
module prcacc_mem #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/prcacc_row_bump.sv
module prcacc_row_bump import prcacc_pkg::*; (
  input  row_t       row_i,
  input  bump_ctrl_t ctrl_i,
  output row_t       row_o
);

  function automatic logic [15:0] inc16(logic [15:0] v, logic en);
    return (en && v != 16'hFFFF) ? v + 16'd1 : v;
  endfunction

  always_comb begin
    row_o.fwd_depth = inc16(row_i.fwd_depth, !ctrl_i.rev);
    row_o.rev_depth = inc16(row_i.rev_depth, ctrl_i.rev);
    row_o.fwd_start = inc16(row_i.fwd_start, !ctrl_i.rev && ctrl_i.at_start);
    row_o.fwd_end   = inc16(row_i.fwd_end, !ctrl_i.rev && ctrl_i.at_end);
    row_o.rev_start = inc16(row_i.rev_start, ctrl_i.rev && ctrl_i.at_end);
    row_o.rev_end   = inc16(row_i.rev_end, ctrl_i.rev && ctrl_i.at_start);
  end

endmodule

// File: sv/prcacc_sat_add.sv
module prcacc_sat_add (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] sum_o
);

  logic [32:0] sum;

  assign sum   = {1'b0, a_i} + {1'b0, b_i};
  assign sum_o = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

endmodule

// File: sv/paired_read_coverage_accumulator.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o  in_data_i (in_t)
// out      output     out_valid_o/out_stall_i out_data_o (out_t)
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
// One item at a time. A record runs setup, one row read-modify-write per
// position of its clipped span, then a histogram update if histogrammed.
// Readback reads the memories; clear zeroes the interval rows. After reset
// a clearing pass over max(MAX_INTERVAL, MAX_INSERT) addresses runs before
// the first item is taken. A stalled result holds the next finish.
module paired_read_coverage_accumulator import prcacc_pkg::*; #(
  parameter int unsigned MAX_INTERVAL = MaxIntervalDef,
  parameter int unsigned MAX_INSERT   = MaxInsertDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i
);

  localparam int unsigned IW   = $clog2(MAX_INTERVAL);
  localparam int unsigned HW   = $clog2(MAX_INSERT);
  localparam int unsigned ClrN = (MAX_INTERVAL > MAX_INSERT) ? MAX_INTERVAL : MAX_INSERT;
  localparam int unsigned CW   = $clog2(ClrN);

  state_e state_q, state_d;

  logic [30:0] first_q, last_q;
  logic [7:0]  minq_q;

  in_t         item_q;
  logic        orient_ok_q, rev_q;
  logic [30:0] last_eff_q;
  logic signed [33:0] right_q;
  logic [32:0] ab_q;
  logic        cov_ok_q, hist_ok_q;
  logic [30:0] s_abs_q, e_abs_q;
  logic [IW-1:0] pos_q, s_q, e_q;
  logic [CW-1:0] clr_cnt_q;
  logic        clr_hist_q;
  logic [31:0] total_q, tally_q;
  out_t        res_q, out_q;
  logic        out_valid_q;

  logic        in_fire, clr_done, out_free;
  logic        row_we, hist_we;
  logic [IW-1:0] row_waddr, row_raddr;
  logic [HW-1:0] hist_waddr, hist_raddr;
  row_t        row_wdata, row_rdata, row_bumped;
  logic [31:0] hist_wdata, hist_rdata;
  bump_ctrl_t  bump_ctrl;
  logic [31:0] add_a, add_b, add_sum;
  logic [32:0] cap;
  logic [IW-1:0] idx_row;
  logic [HW-1:0] idx_bin, hist_bin;
  logic        idx_row_ok, idx_bin_ok;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign clr_done    = clr_hist_q ? (32'(clr_cnt_q) == ClrN - 1)
                                  : (32'(clr_cnt_q) == MAX_INTERVAL - 1);
  assign cap         = {2'b0, first_q} + 33'(MAX_INTERVAL - 1);
  assign idx_row     = IW'(item_q.readback_index);
  assign idx_bin     = HW'(item_q.readback_index);
  assign idx_row_ok  = 32'(item_q.readback_index) < MAX_INTERVAL;
  assign idx_bin_ok  = 32'(item_q.readback_index) < MAX_INSERT;
  assign hist_bin    = HW'(ab_q - 33'd1);

  prcacc_mem #(.Width($bits(row_t)), .Depth(MAX_INTERVAL)) u_row_mem (
    .clk_i  (clk_i),
    .we_i   (row_we),
    .waddr_i(row_waddr),
    .wdata_i(row_wdata),
    .raddr_i(row_raddr),
    .rdata_o(row_rdata)
  );

  prcacc_mem #(.Width(32), .Depth(MAX_INSERT)) u_hist_mem (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(hist_waddr),
    .wdata_i(hist_wdata),
    .raddr_i(hist_raddr),
    .rdata_o(hist_rdata)
  );

  prcacc_row_bump u_row_bump (
    .row_i (row_rdata),
    .ctrl_i(bump_ctrl),
    .row_o (row_bumped)
  );

  prcacc_sat_add u_sat_add (
    .a_i  (add_a),
    .b_i  (add_b),
    .sum_o(add_sum)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:      if (clr_done) state_d = clr_hist_q ? ST_IDLE : ST_FINISH;
      ST_IDLE: begin
        if (in_fire) begin
          unique case (mode_e'(in_data_i.mode))
            MODE_RECORD:   state_d = ST_SETUP1;
            MODE_POSITION,
            MODE_BIN:      state_d = ST_FETCH;
            MODE_CLEAR:    state_d = ST_CLEAR;
            default:       state_d = ST_IDLE;
          endcase
        end
      end
      ST_SETUP1:     state_d = ST_SETUP2;
      ST_SETUP2:     state_d = ST_SETUP3;
      ST_SETUP3:     state_d = cov_ok_q ? ST_ROW_RD : (hist_ok_q ? ST_HIST_RD : ST_FINISH);
      ST_ROW_RD:     state_d = ST_ROW_WR;
      ST_ROW_WR: begin
        if (pos_q == e_q) state_d = hist_ok_q ? ST_HIST_RD : ST_FINISH;
        else              state_d = ST_ROW_RD;
      end
      ST_HIST_RD:    state_d = ST_HIST_BIN;
      ST_HIST_BIN:   state_d = ST_HIST_TOTAL;
      ST_HIST_TOTAL: state_d = ST_HIST_TALLY;
      ST_HIST_TALLY: state_d = ST_FINISH;
      ST_FETCH:      state_d = ST_FETCH_DATA;
      ST_FETCH_DATA: state_d = ST_FINISH;
      ST_FINISH:     if (out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    row_we     = 1'b0;
    row_waddr  = pos_q;
    row_wdata  = row_bumped;
    row_raddr  = pos_q;
    hist_we    = 1'b0;
    hist_waddr = hist_bin;
    hist_wdata = add_sum;
    hist_raddr = hist_bin;
    bump_ctrl.rev      = rev_q;
    bump_ctrl.at_start = (pos_q == s_q);
    bump_ctrl.at_end   = (pos_q == e_q);
    add_a = hist_rdata;
    add_b = 32'd1;
    unique case (state_q)
      ST_CLEAR: begin
        row_we     = 32'(clr_cnt_q) < MAX_INTERVAL;
        row_waddr  = IW'(clr_cnt_q);
        row_wdata  = '0;
        hist_we    = clr_hist_q && (32'(clr_cnt_q) < MAX_INSERT);
        hist_waddr = HW'(clr_cnt_q);
        hist_wdata = '0;
      end
      ST_ROW_WR:   row_we = 1'b1;
      ST_HIST_BIN: hist_we = 1'b1;
      ST_HIST_TOTAL: begin
        add_a = total_q;
        add_b = 32'(ab_q);
      end
      ST_HIST_TALLY: add_a = tally_q;
      ST_FETCH: begin
        row_raddr  = idx_row;
        hist_raddr = idx_bin;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      clr_hist_q  <= 1'b1;
      first_q     <= '0;
      last_q      <= '0;
      minq_q      <= MinQualityReset;
      total_q     <= '0;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FIRST:   first_q <= cfg_data_i;
          CFG_LAST:    last_q  <= cfg_data_i;
          CFG_QUALITY: minq_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_done ? '0 : clr_cnt_q + CW'(1);
        if (clr_done) clr_hist_q <= 1'b0;
      end
      if (state_q == ST_HIST_TOTAL) total_q <= add_sum;
      if (state_q == ST_HIST_TALLY) tally_q <= add_sum;
      if (state_q == ST_FINISH && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          item_q      <= in_data_i;
          res_q       <= '0;
          orient_ok_q <= in_data_i.mate_same_contig && (in_data_i.map_quality >= minq_q) &&
                         (((in_data_i.read_flags & MaskF1R2) == MaskF1R2) ||
                          ((in_data_i.read_flags & MaskF2R1) == MaskF2R1));
          rev_q       <= (in_data_i.read_flags & MaskF1R2) != MaskF1R2;
        end
      end
      ST_SETUP1: begin
        last_eff_q <= ({2'b0, last_q} > cap) ? cap[30:0] : last_q;
        right_q    <= $signed({3'b0, item_q.left_position}) +
                      $signed({{2{item_q.template_length[31]}}, item_q.template_length});
        ab_q       <= item_q.template_length[31]
                      ? (~{1'b1, item_q.template_length} + 33'd1)
                      : {1'b0, item_q.template_length};
      end
      ST_SETUP2: begin
        cov_ok_q  <= orient_ok_q && (last_eff_q >= first_q) &&
                     !item_q.template_length[31] && (item_q.template_length != 32'sd0) &&
                     (item_q.left_position < last_eff_q) &&
                     (right_q > $signed({3'b0, first_q}));
        hist_ok_q <= orient_ok_q && item_q.read_flags[FirstInPairBit] &&
                     (ab_q != 33'd0) && (ab_q <= 33'(MAX_INSERT));
        s_abs_q   <= (item_q.left_position > first_q) ? item_q.left_position : first_q;
        e_abs_q   <= (right_q < $signed({3'b0, last_eff_q})) ? right_q[30:0] : last_eff_q;
      end
      ST_SETUP3: begin
        pos_q          <= IW'(s_abs_q - first_q);
        s_q            <= IW'(s_abs_q - first_q);
        e_q            <= IW'(e_abs_q - first_q);
        res_q.accepted <= cov_ok_q;
      end
      ST_ROW_WR:   pos_q <= pos_q + IW'(1);
      ST_FETCH_DATA: begin
        if (mode_e'(item_q.mode) == MODE_POSITION) begin
          if (idx_row_ok) begin
            res_q.forward_depth  <= row_rdata.fwd_depth;
            res_q.reverse_cover  <= row_rdata.rev_depth;
            res_q.total_depth    <= {1'b0, row_rdata.fwd_depth} + {1'b0, row_rdata.rev_depth};
            res_q.forward_starts <= row_rdata.fwd_start;
            res_q.forward_ends   <= row_rdata.fwd_end;
            res_q.reverse_starts <= row_rdata.rev_start;
            res_q.reverse_ends   <= row_rdata.rev_end;
          end
        end else begin
          res_q.bin_count         <= idx_bin_ok ? hist_rdata : 32'd0;
          res_q.sum_of_inserts    <= total_q;
          res_q.number_of_inserts <= tally_q;
        end
      end
      ST_FINISH:   if (out_free) out_q <= res_q;
      default: ;
    endcase
  end

endmodule

// File: tb/tb_coverage_checker.sv
module tb_coverage_checker import prcacc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] fwd_depth [MaxIntervalDef];
  logic [15:0] rev_depth [MaxIntervalDef];
  logic [15:0] fwd_start [MaxIntervalDef];
  logic [15:0] fwd_end   [MaxIntervalDef];
  logic [15:0] rev_start [MaxIntervalDef];
  logic [15:0] rev_end   [MaxIntervalDef];
  logic [31:0] insert_hist [MaxInsertDef];
  logic [31:0] insert_sum;
  logic [31:0] insert_cnt;

  logic [30:0] ivl_first;
  logic [30:0] ivl_last;
  logic [7:0]  min_qual;

  out_t expected_q[$];

  function automatic logic [15:0] inc16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [31:0] add32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void clear_interval();
    for (int i = 0; i < MaxIntervalDef; i++) begin
      fwd_depth[i] = '0; rev_depth[i] = '0; fwd_start[i] = '0;
      fwd_end[i] = '0; rev_start[i] = '0; rev_end[i] = '0;
    end
  endfunction

  function automatic out_t coverage_predict(in_t x);
    out_t r;
    int orient;
    longint f, l, cap, p, tl, rt, ab, s, e, i;
    r = '0;
    case (mode_e'(x.mode))
      MODE_RECORD: begin
        orient = 0;
        if (x.mate_same_contig && x.map_quality >= min_qual) begin
          if ((x.read_flags & MaskF1R2) == MaskF1R2) orient = 1;
          else if ((x.read_flags & MaskF2R1) == MaskF2R1) orient = 2;
        end
        if (orient != 0) begin
          f = longint'(ivl_first);
          l = longint'(ivl_last);
          cap = f + MaxIntervalDef - 1;
          if (l > cap) l = cap;
          p = longint'(x.left_position);
          tl = longint'($signed(x.template_length));
          rt = p + tl;
          ab = (tl < 0) ? -tl : tl;
          if (l >= f && tl > 0 && p < l && rt > f) begin
            s = ((p > f) ? p : f) - f;
            e = ((rt < l) ? rt : l) - f;
            for (i = s; i <= e; i++) begin
              if (orient == 1) fwd_depth[i] = inc16(fwd_depth[i]);
              else rev_depth[i] = inc16(rev_depth[i]);
            end
            if (orient == 1) begin
              fwd_start[s] = inc16(fwd_start[s]);
              fwd_end[e] = inc16(fwd_end[e]);
            end else begin
              rev_start[e] = inc16(rev_start[e]);
              rev_end[s] = inc16(rev_end[s]);
            end
            r.accepted = 1'b1;
          end
          if (x.read_flags[FirstInPairBit] && ab > 0 && ab <= MaxInsertDef) begin
            insert_hist[ab - 1] = add32(insert_hist[ab - 1], 32'd1);
            insert_sum = add32(insert_sum, 32'(ab));
            insert_cnt = add32(insert_cnt, 32'd1);
          end
        end
      end
      MODE_POSITION: begin
        i = longint'(x.readback_index);
        r.forward_depth = fwd_depth[i];
        r.reverse_cover = rev_depth[i];
        r.total_depth = {1'b0, fwd_depth[i]} + {1'b0, rev_depth[i]};
        r.forward_starts = fwd_start[i];
        r.forward_ends = fwd_end[i];
        r.reverse_starts = rev_start[i];
        r.reverse_ends = rev_end[i];
      end
      MODE_BIN: begin
        if (x.readback_index < MaxInsertDef) r.bin_count = insert_hist[x.readback_index];
        r.sum_of_inserts = insert_sum;
        r.number_of_inserts = insert_cnt;
      end
      default: clear_interval();
    endcase
    return r;
  endfunction

  function automatic bit field_ok(string name, logic [31:0] got, logic [31:0] want);
    if (got === want) return 1'b1;
    if (errors_o < 10) $display("mismatch %s: expected %0h actual %0h", name, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    bit ok;
    if (!rst_ni) begin
      ivl_first = '0;
      ivl_last = '0;
      min_qual = MinQualityReset;
      clear_interval();
      for (int i = 0; i < MaxInsertDef; i++) insert_hist[i] = '0;
      insert_sum = '0;
      insert_cnt = '0;
      expected_q.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FIRST:   ivl_first = cfg_data_i;
          CFG_LAST:    ivl_last = cfg_data_i;
          CFG_QUALITY: min_qual = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_q = {expected_q, coverage_predict(in_data_i)};
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected result transfer");
          errors_o++;
        end else begin
          want = expected_q.pop_front();
          ok = 1'b1;
          ok &= field_ok("accepted", 32'(out_data_i.accepted), 32'(want.accepted));
          ok &= field_ok("forward_depth", 32'(out_data_i.forward_depth),
                         32'(want.forward_depth));
          ok &= field_ok("reverse_cover", 32'(out_data_i.reverse_cover),
                         32'(want.reverse_cover));
          ok &= field_ok("total_depth", 32'(out_data_i.total_depth), 32'(want.total_depth));
          ok &= field_ok("forward_starts", 32'(out_data_i.forward_starts),
                         32'(want.forward_starts));
          ok &= field_ok("forward_ends", 32'(out_data_i.forward_ends),
                         32'(want.forward_ends));
          ok &= field_ok("reverse_starts", 32'(out_data_i.reverse_starts),
                         32'(want.reverse_starts));
          ok &= field_ok("reverse_ends", 32'(out_data_i.reverse_ends),
                         32'(want.reverse_ends));
          ok &= field_ok("bin_count", out_data_i.bin_count, want.bin_count);
          ok &= field_ok("sum_of_inserts", out_data_i.sum_of_inserts, want.sum_of_inserts);
          ok &= field_ok("number_of_inserts", out_data_i.number_of_inserts,
                         want.number_of_inserts);
          if (!ok) errors_o++;
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// File: tb/tb_top.sv
module tb_top import prcacc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CycleLimit = 6000000;
  localparam longint PosMax = 64'h7FFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [30:0] cfg_data;
  int          errors;
  int          pending;
  bit          no_idle;
  longint      cycles = 0;

  paired_read_coverage_accumulator dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  tb_coverage_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // result side: random stall before each transfer
  initial begin
    int n;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      n = no_idle ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [30:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_interval(longint f, longint l, int q);
    wait_drained();
    write_reg(CFG_FIRST, f[30:0]);
    write_reg(CFG_LAST, l[30:0]);
    write_reg(CFG_QUALITY, q[30:0]);
  endtask

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send(in_t x);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic in_t rec(logic [11:0] fl, int q, bit same, longint p, longint tl);
    in_t x;
    x = '0;
    x.mode = MODE_RECORD;
    x.read_flags = fl;
    x.map_quality = q[7:0];
    x.mate_same_contig = same;
    x.left_position = p[30:0];
    x.template_length = tl[31:0];
    return x;
  endfunction

  function automatic in_t probe(mode_e m, int idx);
    in_t x;
    x = '0;
    x.mode = m;
    x.readback_index = idx[14:0];
    return x;
  endfunction

  function automatic in_t make_item(longint f, longint l, int q);
    in_t x;
    longint span, lim, p, tl;
    int r;
    x = '0;
    x.read_flags = 12'($urandom);
    x.map_quality = 8'($urandom);
    x.mate_same_contig = 1'($urandom);
    x.left_position = 31'($urandom);
    x.template_length = $urandom;
    x.readback_index = 15'($urandom);
    span = (l >= f) ? l - f : 64;
    if (span > 32767) span = 32767;
    lim = (span > 600) ? 600 : span;
    r = $urandom_range(0, 999);
    if (r < 3) begin
      x.mode = MODE_CLEAR;
    end else if (r < 170) begin
      x.mode = MODE_POSITION;
      x.readback_index = ($urandom_range(0, 4) == 0) ? 15'($urandom)
                       : 15'($urandom_range(0, int'(span) + 5));
    end else if (r < 290) begin
      x.mode = MODE_BIN;
      if ($urandom_range(0, 4) != 0) x.readback_index = 15'($urandom_range(0, 1023));
    end else begin
      x.mode = MODE_RECORD;
      r = $urandom_range(0, 9);
      if (r < 5) x.read_flags |= MaskF1R2;
      else if (r < 8) begin
        x.read_flags |= MaskF2R1;
        x.read_flags[FirstInPairBit] = 1'b0;
      end
      if ($urandom_range(0, 9) < 8) x.map_quality = 8'($urandom_range(q, 255));
      x.mate_same_contig = ($urandom_range(0, 9) != 0);
      p = f - span / 2 - 40 + longint'($urandom_range(0, int'(span + span / 2 + 80)));
      if (p < 0) p = 0;
      if (p > PosMax) p = PosMax;
      x.left_position = p[30:0];
      r = $urandom_range(0, 9);
      if (r < 6) tl = longint'($urandom_range(1, int'(lim) + 80));
      else if (r == 6) tl = -longint'($urandom_range(1, 1200));
      else if (r == 7) tl = longint'($urandom_range(1, 1000));
      else if (r == 8) tl = longint'($urandom_range(0, 3));
      else tl = (span > 600) ? longint'($urandom_range(1, 1000)) : longint'($urandom);
      x.template_length = tl[31:0];
    end
    return x;
  endfunction

  initial begin
    longint pf [7];
    longint pl [7];
    int     pq [7];
    int     pn [7];
    longint w;
    no_idle = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_NONE;
    cfg_data = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    set_interval(10, 40, 20);
    send(rec(MaskF1R2, 20, 1, 5, 10));
    send(rec(MaskF2R1, 255, 1, 20, 30));
    send(rec(MaskF1R2, 19, 1, 12, 5));
    send(rec(MaskF1R2, 30, 0, 12, 5));
    send(rec(MaskF1R2, 30, 1, 15, -1000));
    send(rec(MaskF1R2, 30, 1, 15, 1001));
    send(rec(MaskF1R2, 30, 1, 15, 0));
    send(rec(MaskF1R2, 30, 1, 40, 3));
    send(rec(MaskF1R2, 30, 1, 0, 10));
    send(rec(12'hFFF, 30, 1, 11, 2));
    send(rec(12'h000, 30, 1, 11, 2));
    send(rec(MaskF1R2, 30, 1, 12, 64'h7FFF_FFFF));
    send(rec(MaskF2R1, 30, 1, 12, -64'sd2147483648));
    send(rec(MaskF1R2, 30, 1, PosMax, 1));
    send(probe(MODE_POSITION, 0));
    send(probe(MODE_POSITION, 10));
    send(probe(MODE_POSITION, 30));
    send(probe(MODE_POSITION, 32767));
    send(probe(MODE_BIN, 0));
    send(probe(MODE_BIN, 999));
    send(probe(MODE_BIN, 1000));
    send(probe(MODE_BIN, 32767));
    send(probe(MODE_CLEAR, 0));
    send(probe(MODE_POSITION, 10));
    send(probe(MODE_BIN, 999));

    w = longint'($urandom_range(0, 150));
    pf = '{1000, 0, PosMax - 255, 5000, 0, 0, PosMax};
    pl = '{1063, 200, PosMax, 4000, PosMax, 0, PosMax};
    pq = '{20, 0, 255, 30, 10, 0, 20};
    pn = '{350, 300, 150, 80, 120, 350, 100};
    pf[5] = longint'($urandom_range(0, 32'h7FFF_FF00));
    pl[5] = pf[5] + w;
    pq[5] = $urandom_range(0, 255);
    for (int ph = 0; ph < 7; ph++) begin
      set_interval(pf[ph], pl[ph], pq[ph]);
      no_idle = (ph == 1);
      for (int k = 0; k < pn[ph]; k++) send(make_item(pf[ph], pl[ph], pq[ph]));
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
